// ===== design/tccw_pkg.sv =====
package tccw_pkg;

  localparam int ColW = 7;
  localparam int ByteW = 8;
  localparam int CfgIdxW = 1;

  localparam int RowWidthDefault = 80;
  localparam int TabStepDefault = 8;
  localparam int QueueDepthDefault = 4;

  localparam logic [ByteW-1:0] NormalAttrReset = 8'h07;
  localparam logic [ByteW-1:0] BrightAttrReset = 8'h0f;

  localparam logic [ByteW-1:0] ChNl = 8'h0a;
  localparam logic [ByteW-1:0] ChCr = 8'h0d;
  localparam logic [ByteW-1:0] ChTab = 8'h09;
  localparam logic [ByteW-1:0] ChEsc = 8'h1b;
  localparam logic [ByteW-1:0] ChLbrack = 8'h5b;
  localparam logic [ByteW-1:0] ChZero = 8'h30;
  localparam logic [ByteW-1:0] ChNine = 8'h39;
  localparam logic [ByteW-1:0] ChSgrEnd = 8'h6d;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNormalAttr = 1'b0,
    CfgBrightAttr = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EscNone = 2'd0,
    EscSeen = 2'd1,
    EscCsi  = 2'd2
  } esc_phase_e;

  typedef enum logic {
    ActCell   = 1'b0,
    ActScroll = 1'b1
  } action_e;

  // A queue entry holds an optional leading scroll and an optional trailing command.
  typedef struct packed {
    logic                   lead;
    logic                   tail_valid;
    action_e                tail_action;
    logic [ColW-1:0]        column;
    logic [ByteW-1:0]       glyph;
    logic [ByteW-1:0]       attr;
  } cmd_entry_t;

endpackage

// ===== design/tccw_if.sv =====
interface tccw_char_if;
  logic                         valid;
  logic                         ready;
  logic [tccw_pkg::ByteW-1:0]   char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface tccw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [tccw_pkg::ColW-1:0]    cell_column;
  logic [tccw_pkg::ByteW-1:0]   glyph;
  logic [tccw_pkg::ByteW-1:0]   cell_attribute;
  logic                         last;

  modport source (output valid, output action, output cell_column, output glyph,
                  output cell_attribute, output last, input ready);
  modport sink (input valid, input action, input cell_column, input glyph,
                input cell_attribute, input last, output ready);
endinterface

// ===== design/tccw_front.sv =====
module tccw_front #(
  parameter int RowWidth = tccw_pkg::RowWidthDefault,
  parameter int TabStep = tccw_pkg::TabStepDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tccw_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tccw_pkg::ByteW-1:0]          cfg_data_i,
  tccw_char_if.sink                           char_i,
  output logic                                push_valid_o,
  output tccw_pkg::cmd_entry_t                push_entry_o,
  input  logic                                push_ready_i
);

  localparam int ColW = tccw_pkg::ColW;
  localparam int NumCols = 2 ** ColW;

  logic [ColW-1:0]              tab_next [NumCols];

  logic [ColW-1:0]              cursor_q, cursor_d;
  logic                         started_q;
  tccw_pkg::esc_phase_e         phase_q, phase_d;
  logic                         pnz_q, pnz_d;
  logic [tccw_pkg::ByteW-1:0]   attr_q, attr_d;
  logic [tccw_pkg::ByteW-1:0]   normal_q, bright_q;

  logic                         accept;
  logic                         ordinary;
  logic [ColW-1:0]              col;
  logic [tccw_pkg::ByteW-1:0]   c;
  tccw_pkg::cmd_entry_t         entry;

  for (genvar g = 0; g < NumCols; g++) begin : g_tab
    localparam int Next = ((g / TabStep) + 1) * TabStep;
    localparam int Sat = (Next > RowWidth) ? RowWidth : Next;
    assign tab_next[g] = ColW'(Sat);
  end

  assign c = char_i.char_in;
  assign char_i.ready = push_ready_i;
  assign accept = char_i.valid && push_ready_i;

  always_comb begin
    ordinary = 1'b0;
    phase_d = phase_q;
    pnz_d = pnz_q;
    attr_d = attr_q;
    col = started_q ? cursor_q : '0;
    cursor_d = col;
    entry.lead = !started_q;
    entry.tail_valid = 1'b0;
    entry.tail_action = tccw_pkg::ActCell;
    entry.column = '0;
    entry.glyph = '0;
    entry.attr = '0;

    case (phase_q)
      tccw_pkg::EscSeen: begin
        if (c == tccw_pkg::ChLbrack) begin
          phase_d = tccw_pkg::EscCsi;
        end else begin
          ordinary = 1'b1;
        end
      end
      tccw_pkg::EscCsi: begin
        if (c >= tccw_pkg::ChZero && c <= tccw_pkg::ChNine) begin
          if (c != tccw_pkg::ChZero) begin
            pnz_d = 1'b1;
          end
        end else if (c == tccw_pkg::ChSgrEnd) begin
          attr_d = pnz_q ? bright_q : normal_q;
          phase_d = tccw_pkg::EscNone;
        end else begin
          ordinary = 1'b1;
        end
      end
      default: begin
        ordinary = 1'b1;
      end
    endcase

    if (ordinary) begin
      phase_d = tccw_pkg::EscNone;
      if (c == tccw_pkg::ChNl) begin
        entry.tail_valid = 1'b1;
        entry.tail_action = tccw_pkg::ActScroll;
        cursor_d = '0;
      end else if (c == tccw_pkg::ChCr) begin
        cursor_d = '0;
      end else if (c == tccw_pkg::ChTab) begin
        cursor_d = tab_next[col];
      end else if (c == tccw_pkg::ChEsc) begin
        phase_d = tccw_pkg::EscSeen;
        pnz_d = 1'b0;
      end else begin
        if (col >= ColW'(RowWidth)) begin
          entry.lead = 1'b1;
          col = '0;
        end
        entry.tail_valid = 1'b1;
        entry.tail_action = tccw_pkg::ActCell;
        entry.column = col;
        entry.glyph = c;
        entry.attr = attr_q;
        cursor_d = col + ColW'(1);
      end
    end
  end

  assign push_entry_o = entry;
  assign push_valid_o = accept && (entry.lead || entry.tail_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      started_q <= 1'b0;
      phase_q <= tccw_pkg::EscNone;
      pnz_q <= 1'b0;
      attr_q <= tccw_pkg::NormalAttrReset;
    end else if (accept) begin
      cursor_q <= cursor_d;
      started_q <= 1'b1;
      phase_q <= phase_d;
      pnz_q <= pnz_d;
      attr_q <= attr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q <= tccw_pkg::NormalAttrReset;
      bright_q <= tccw_pkg::BrightAttrReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tccw_pkg::CfgNormalAttr) begin
        normal_q <= cfg_data_i;
      end
      if (cfg_idx_i == tccw_pkg::CfgBrightAttr) begin
        bright_q <= cfg_data_i;
      end
    end
  end

endmodule

// ===== design/tccw_queue.sv =====
module tccw_queue #(
  parameter int Depth = tccw_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  tccw_pkg::cmd_entry_t  push_entry_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output tccw_pkg::cmd_entry_t  pop_entry_o,
  input  logic                  pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tccw_pkg::cmd_entry_t   mem_q [Depth];
  logic [PtrW-1:0]        wr_q, rd_q;
  logic [CntW-1:0]        cnt_q;
  logic                   push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_entry_o = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/tccw_back.sv =====
module tccw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  tccw_pkg::cmd_entry_t  head_i,
  output logic                  pop_o,
  tccw_cmd_if.source            cmd_o
);

  logic                               out_valid_q, out_valid_d;
  logic                               out_action_q;
  logic [tccw_pkg::ColW-1:0]          out_column_q;
  logic [tccw_pkg::ByteW-1:0]         out_glyph_q;
  logic [tccw_pkg::ByteW-1:0]         out_attr_q;
  logic                               out_last_q;
  logic                               lead_done_q, lead_done_d;

  logic                               load;
  logic                               issue_lead;
  logic                               final_cmd;
  logic                               res_action;
  logic [tccw_pkg::ColW-1:0]          res_column;
  logic [tccw_pkg::ByteW-1:0]         res_glyph;
  logic [tccw_pkg::ByteW-1:0]         res_attr;

  always_comb begin
    load = head_valid_i && (!out_valid_q || cmd_o.ready);
    issue_lead = head_i.lead && !lead_done_q;
    final_cmd = !issue_lead || !head_i.tail_valid;
    if (issue_lead) begin
      res_action = tccw_pkg::ActScroll;
      res_column = '0;
      res_glyph = '0;
      res_attr = '0;
    end else begin
      res_action = head_i.tail_action;
      res_column = head_i.column;
      res_glyph = head_i.glyph;
      res_attr = head_i.attr;
    end
    pop_o = load && final_cmd;
    lead_done_d = load ? !final_cmd : lead_done_q;
    out_valid_d = load || (out_valid_q && !cmd_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lead_done_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      lead_done_q <= lead_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_action_q <= res_action;
      out_column_q <= res_column;
      out_glyph_q <= res_glyph;
      out_attr_q <= res_attr;
      out_last_q <= final_cmd;
    end
  end

  assign cmd_o.valid = out_valid_q;
  assign cmd_o.action = out_action_q;
  assign cmd_o.cell_column = out_column_q;
  assign cmd_o.glyph = out_glyph_q;
  assign cmd_o.cell_attribute = out_attr_q;
  assign cmd_o.last = out_last_q;

endmodule

// ===== design/text_console_char_writer.sv =====
// Character writer for a console that shows only its bottom text row.
// Bytes arrive on char_i, one per transfer. Each byte yields zero, one or
// two commands on cmd_o: write a cell at a column with a glyph and an
// attribute, or scroll up one line and clear the bottom row. The field
// last marks the final command of a byte. ESC [ digits m selects the
// bright or the normal attribute from the two configuration registers,
// which are written through cfg_we_i, cfg_idx_i and cfg_data_i.
// A front end decodes each byte in the cycle it is taken and pushes its
// commands into a queue of QueueDepth entries; a back end drains the queue
// into an output register. A byte's first command passes through the queue
// and the output register before it is valid on cmd_o. One byte is taken
// per cycle while the queue has room; a byte with two commands puts them on
// cmd_o one after the other, the scroll first. When the receiver stalls,
// the output register holds and the queue fills, after which char_i.ready
// drops. Reset clears the cursor, the escape state and the queue and
// restores the attributes; the first byte after reset is preceded by a scroll.
module text_console_char_writer #(
  parameter int RowWidth = tccw_pkg::RowWidthDefault,
  parameter int TabStep = tccw_pkg::TabStepDefault,
  parameter int QueueDepth = tccw_pkg::QueueDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tccw_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tccw_pkg::ByteW-1:0]      cfg_data_i,
  tccw_char_if.sink                       char_i,
  tccw_cmd_if.source                      cmd_o
);

  logic                   push_valid, push_ready;
  tccw_pkg::cmd_entry_t   push_entry;
  logic                   head_valid, pop;
  tccw_pkg::cmd_entry_t   head_entry;

  tccw_front #(
    .RowWidth(RowWidth),
    .TabStep(TabStep)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .char_i(char_i),
    .push_valid_o(push_valid),
    .push_entry_o(push_entry),
    .push_ready_i(push_ready)
  );

  tccw_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_valid_i(push_valid),
    .push_entry_i(push_entry),
    .push_ready_o(push_ready),
    .pop_valid_o(head_valid),
    .pop_entry_o(head_entry),
    .pop_i(pop)
  );

  tccw_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .head_valid_i(head_valid),
    .head_i(head_entry),
    .pop_o(pop),
    .cmd_o(cmd_o)
  );

endmodule

// ===== design/tccw_checker.sv =====
module tccw_checker #(
  parameter int RowWidth = tccw_pkg::RowWidthDefault
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cmd_valid,
  input logic                           cmd_ready,
  input logic                           cmd_action,
  input logic [tccw_pkg::ColW-1:0]      cmd_column,
  input logic [tccw_pkg::ByteW-1:0]     cmd_glyph,
  input logic [tccw_pkg::ByteW-1:0]     cmd_attr,
  input logic                           cmd_last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_action) &&
      $stable(cmd_column) && $stable(cmd_glyph) && $stable(cmd_last))
    else $error("Stalled command changed before its transfer.");

  a_scroll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_action == tccw_pkg::ActScroll |->
      cmd_column == '0 && cmd_glyph == '0 && cmd_attr == '0)
    else $error("Scroll command carries nonzero cell fields.");

  a_cell_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_action == tccw_pkg::ActCell |->
      cmd_column < tccw_pkg::ColW'(RowWidth))
    else $error("Cell written beyond the row end.");

  a_cell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_action == tccw_pkg::ActCell |-> cmd_last)
    else $error("Cell write is not the final command of its byte.");

endmodule

bind text_console_char_writer tccw_checker #(
  .RowWidth(RowWidth)
) u_tccw_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .cmd_valid(cmd_o.valid),
  .cmd_ready(cmd_o.ready),
  .cmd_action(cmd_o.action),
  .cmd_column(cmd_o.cell_column),
  .cmd_glyph(cmd_o.glyph),
  .cmd_attr(cmd_o.cell_attribute),
  .cmd_last(cmd_o.last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int ColW = tccw_pkg::ColW;
  localparam int ByteW = tccw_pkg::ByteW;
  localparam int CfgIdxW = tccw_pkg::CfgIdxW;
  localparam int RowW = tccw_pkg::RowWidthDefault;
  localparam int TabW = tccw_pkg::TabStepDefault;
  localparam int LongHoldCycles = 80;
  localparam int SettleCycles = 10;

  typedef struct packed {
    tccw_pkg::action_e action;
    logic [ColW-1:0]   column;
    logic [ByteW-1:0]  glyph;
    logic [ByteW-1:0]  attr;
    logic              last;
  } console_cmd_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [ByteW-1:0]    cfg_data_i;

  tccw_char_if char_if ();
  tccw_cmd_if  cmd_if ();

  text_console_char_writer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .char_i     (char_if),
    .cmd_o      (cmd_if)
  );

  // Console state as the block should hold it.
  logic [ByteW-1:0]     normal_attr_reg;
  logic [ByteW-1:0]     bright_attr_reg;
  int                   cursor;
  logic                 console_started;
  tccw_pkg::esc_phase_e esc_state;
  logic                 sgr_param_nz;
  logic [ByteW-1:0]     active_attr;

  logic [ByteW-1:0] pending_chars[$];
  console_cmd_t     expected_cmds[$];

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit long_hold_armed;

  int mismatch_count;
  int chars_sent;
  int cells_seen;
  int scrolls_seen;
  int reg_writes;

  function automatic void append_cmd(tccw_pkg::action_e act, int col, logic [ByteW-1:0] ch,
                                     logic [ByteW-1:0] attr);
    console_cmd_t cmd;
    cmd.action = act;
    cmd.column = col[ColW-1:0];
    cmd.glyph  = ch;
    cmd.attr   = attr;
    cmd.last   = 1'b0;
    expected_cmds.push_back(cmd);
  endfunction

  function automatic void predict_console(logic [ByteW-1:0] c);
    int  n_before;
    int  next_stop;
    bit  consumed;
    n_before = expected_cmds.size();
    consumed = 1'b0;
    if (!console_started) begin
      console_started = 1'b1;
      append_cmd(tccw_pkg::ActScroll, 0, '0, '0);
      cursor = 0;
    end
    case (esc_state)
      tccw_pkg::EscSeen: begin
        if (c == tccw_pkg::ChLbrack) begin
          esc_state = tccw_pkg::EscCsi;
          consumed = 1'b1;
        end else begin
          esc_state = tccw_pkg::EscNone;
        end
      end
      tccw_pkg::EscCsi: begin
        if (c >= tccw_pkg::ChZero && c <= tccw_pkg::ChNine) begin
          if (c != tccw_pkg::ChZero) sgr_param_nz = 1'b1;
          consumed = 1'b1;
        end else if (c == tccw_pkg::ChSgrEnd) begin
          active_attr = sgr_param_nz ? bright_attr_reg : normal_attr_reg;
          esc_state = tccw_pkg::EscNone;
          consumed = 1'b1;
        end else begin
          esc_state = tccw_pkg::EscNone;
        end
      end
      default: esc_state = tccw_pkg::EscNone;
    endcase
    if (!consumed) begin
      if (c == tccw_pkg::ChNl) begin
        append_cmd(tccw_pkg::ActScroll, 0, '0, '0);
        cursor = 0;
      end else if (c == tccw_pkg::ChCr) begin
        cursor = 0;
      end else if (c == tccw_pkg::ChTab) begin
        next_stop = (cursor / TabW + 1) * TabW;
        cursor = (next_stop > RowW) ? RowW : next_stop;
      end else if (c == tccw_pkg::ChEsc) begin
        esc_state = tccw_pkg::EscSeen;
        sgr_param_nz = 1'b0;
      end else begin
        if (cursor >= RowW) begin
          append_cmd(tccw_pkg::ActScroll, 0, '0, '0);
          cursor = 0;
        end
        append_cmd(tccw_pkg::ActCell, cursor, c, active_attr);
        cursor++;
      end
    end
    if (expected_cmds.size() > n_before) expected_cmds[expected_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic void queue_char(logic [ByteW-1:0] c);
    pending_chars.push_back(c);
  endfunction

  function automatic void queue_sgr(int digits);
    queue_char(tccw_pkg::ChEsc);
    queue_char(tccw_pkg::ChLbrack);
    for (int i = 0; i < digits; i++) begin
      queue_char(ByteW'($urandom_range(tccw_pkg::ChZero, tccw_pkg::ChNine)));
    end
    queue_char(tccw_pkg::ChSgrEnd);
  endfunction

  // Mostly well-formed console traffic: text runs of up to 40 characters,
  // tabs, line controls and attribute sequences, mixed with broken escapes and noise.
  function automatic void queue_console_traffic(int count);
    int start;
    int pick;
    int run_len;
    start = pending_chars.size();
    while (pending_chars.size() - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run_len = $urandom_range(1, 40);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 99) < 85) queue_char(ByteW'($urandom_range(8'h20, 8'h7e)));
          else queue_char(ByteW'($urandom_range(0, 255)));
        end
      end else if (pick < 52) begin
        run_len = $urandom_range(1, 3);
        for (int i = 0; i < run_len; i++) queue_char(tccw_pkg::ChTab);
      end else if (pick < 67) begin
        queue_sgr($urandom_range(0, 3));
      end else if (pick < 75) begin
        queue_char(tccw_pkg::ChNl);
      end else if (pick < 80) begin
        queue_char(tccw_pkg::ChCr);
      end else if (pick < 85) begin
        queue_char(tccw_pkg::ChEsc);
        queue_char(ByteW'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        queue_char(tccw_pkg::ChEsc);
        queue_char(tccw_pkg::ChLbrack);
        run_len = $urandom_range(0, 2);
        for (int i = 0; i < run_len; i++) begin
          queue_char(ByteW'($urandom_range(tccw_pkg::ChZero, tccw_pkg::ChNine)));
        end
        queue_char(ByteW'($urandom_range(0, 255)));
      end else begin
        queue_char(ByteW'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic write_attr_reg(tccw_pkg::cfg_idx_e idx, logic [ByteW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == tccw_pkg::CfgNormalAttr) normal_attr_reg = value;
    else bright_attr_reg = value;
    reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_console_idle();
    @(negedge clk_i);
    while (pending_chars.size() > 0 || char_if.valid) @(negedge clk_i);
    while (expected_cmds.size() > 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d characters still pending and %0d commands expected",
             pending_chars.size(), expected_cmds.size());
    $display("Verification failed");
    $finish;
  end

  // Sender: offers the pending characters, predicting the commands of each transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      char_if.valid <= 1'b0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        predict_console(char_if.char_in);
        chars_sent++;
      end
      if (!char_if.valid || char_if.ready) begin
        if (pending_chars.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          char_if.valid   <= 1'b1;
          char_if.char_in <= pending_chars.pop_front();
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the block fill up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      cmd_if.ready <= 1'b0;
    end else if (long_hold_armed && char_if.valid) begin
      long_hold_armed = 1'b0;
      hold_left = LongHoldCycles;
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin : check_cmd
      console_cmd_t got;
      console_cmd_t want;
      got.action = tccw_pkg::action_e'(cmd_if.action);
      got.column = cmd_if.cell_column;
      got.glyph  = cmd_if.glyph;
      got.attr   = cmd_if.cell_attribute;
      got.last   = cmd_if.last;
      if (got.action == tccw_pkg::ActScroll) scrolls_seen++;
      else cells_seen++;
      if (expected_cmds.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%t: unexpected command action=%0d col=%0d glyph=%h attr=%h last=%0d",
                   $realtime, got.action, got.column, got.glyph, got.attr, got.last);
      end else begin
        want = expected_cmds.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%t: command mismatch: expected action=%0d col=%0d glyph=%h attr=%h last=%0d",
                     $realtime, want.action, want.column, want.glyph, want.attr, want.last);
            $display("%t: command mismatch: got action=%0d col=%0d glyph=%h attr=%h last=%0d",
                     $realtime, got.action, got.column, got.glyph, got.attr, got.last);
          end
        end
      end
    end
  end

  initial begin
    int sender_mode[4];
    int recv_mode[4];
    sender_mode = '{0, 45, 0, 33};
    recv_mode   = '{0, 0, 45, 33};

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = tccw_pkg::CfgNormalAttr;
    cfg_data_i      = '0;
    char_if.valid   = 1'b0;
    char_if.char_in = '0;
    cmd_if.ready    = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    long_hold_armed = 1'b0;
    mismatch_count  = 0;
    chars_sent      = 0;
    cells_seen      = 0;
    scrolls_seen    = 0;
    reg_writes      = 0;
    normal_attr_reg = tccw_pkg::NormalAttrReset;
    bright_attr_reg = tccw_pkg::BrightAttrReset;
    cursor          = 0;
    console_started = 1'b0;
    esc_state       = tccw_pkg::EscNone;
    sgr_param_nz    = 1'b0;
    active_attr     = tccw_pkg::NormalAttrReset;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first character scrolls once before it is written.
    queue_char(8'h41);
    queue_char(8'h00);
    queue_char(8'hff);
    queue_char(tccw_pkg::ChTab);
    queue_char(tccw_pkg::ChCr);
    queue_char(tccw_pkg::ChNl);
    queue_sgr(1);
    queue_char(8'h42);
    queue_sgr(0);
    queue_char(8'h43);
    queue_char(tccw_pkg::ChEsc);
    queue_char(tccw_pkg::ChLbrack);
    queue_char(tccw_pkg::ChZero);
    queue_char(tccw_pkg::ChSgrEnd);
    // An escape cut short writes the byte that broke it.
    queue_char(tccw_pkg::ChEsc);
    queue_char(8'h78);
    queue_char(tccw_pkg::ChEsc);
    queue_char(tccw_pkg::ChLbrack);
    queue_char(8'h71);
    queue_char(8'h01);
    wait_console_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_attr_reg(tccw_pkg::CfgNormalAttr, 8'h00);
          write_attr_reg(tccw_pkg::CfgBrightAttr, 8'hff);
        end
        1: begin
          write_attr_reg(tccw_pkg::CfgNormalAttr, 8'hff);
          write_attr_reg(tccw_pkg::CfgBrightAttr, 8'h00);
        end
        default: begin
          write_attr_reg(tccw_pkg::CfgNormalAttr, ByteW'($urandom_range(0, 255)));
          write_attr_reg(tccw_pkg::CfgBrightAttr, ByteW'($urandom_range(0, 255)));
        end
      endcase
      sender_idle_pct = sender_mode[ph];
      recv_stall_pct  = recv_mode[ph];
      if (ph == 0) long_hold_armed = 1'b1;
      queue_console_traffic(195);
      wait_console_idle();
    end

    $display("Sent %0d characters; checked %0d cell writes and %0d scrolls.",
             chars_sent, cells_seen, scrolls_seen);
    $display("Covered %0d attribute register writes, four stall modes and one long hold-off.",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tccw_pkg.sv
design/tccw_if.sv
design/tccw_front.sv
design/tccw_queue.sv
design/tccw_back.sv
design/text_console_char_writer.sv
design/tccw_checker.sv
tb/tb_top.sv
